// ===== design/mbrot_pkg.sv =====
// Shared constants, types and helper functions of the Mandelbrot escape-time pixel core.
`default_nettype none

package mbrot_pkg;

   // Fixed-point word and field widths
   localparam int FX_W        = 40;
   localparam int HALF_W      = FX_W / 2;
   localparam int COL_W       = 10;
   localparam int ROW_W       = 10;
   localparam int ADDR_W      = 19;
   localparam int COUNT_W     = 8;
   localparam int LEVEL_W     = 8;
   localparam int OFFSET_W    = 21;
   localparam int STEP_W      = 29;
   localparam int LIMIT_W     = 8;
   localparam int THRESH_W    = 36;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 36;

   // Defaults for the top-level parameters
   localparam int DEF_IMAGE_WIDTH   = 800;
   localparam int DEF_IMAGE_HEIGHT  = 600;
   localparam int DEF_FRACTION_BITS = 28;
   localparam int DEF_QUEUE_DEPTH   = 2;

   // Colour mapping constants
   localparam int COLOUR_MODULUS = 255;
   localparam int COLOUR_MULT    = 123;

   localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
   localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_X         = 3'd0,
      CSR_OFFSET_Y         = 3'd1,
      CSR_STEP_X           = 3'd2,
      CSR_STEP_Y           = 3'd3,
      CSR_ITERATION_LIMIT  = 3'd4,
      CSR_ESCAPE_THRESHOLD = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [OFFSET_W-1:0] offset_y;
      logic [STEP_W-1:0]          step_x;
      logic [STEP_W-1:0]          step_y;
      logic [LIMIT_W-1:0]         iteration_limit;
      logic [THRESH_W-1:0]        escape_threshold;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      offset_x:         -21'sd400,
      offset_y:         21'sd0,
      step_x:           29'd603980,
      step_y:           29'd603980,
      iteration_limit:  8'd255,
      escape_threshold: 36'd2684354560
   };

   // One classified point travelling from the front end to the iteration engine
   typedef struct packed {
      logic signed [FX_W-1:0] cx;
      logic signed [FX_W-1:0] cy;
      logic [ADDR_W-1:0]      pixel_address;
   } point_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_COMBINE,
      ST_UPDATE,
      ST_DONE
   } back_state_type;

   // Clamp a two-bit-wider sum to the fixed-point range
   function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [FX_W+1:0] v);
      logic signed [FX_W-1:0] res;
      if ((v[FX_W+1] == v[FX_W]) && (v[FX_W] == v[FX_W-1])) begin
         res = v[FX_W-1:0];
      end else if (v[FX_W+1]) begin
         res = FX_MIN;
      end else begin
         res = FX_MAX;
      end
      return res;
   endfunction

   function automatic logic [LEVEL_W-1:0] blue_green_of(input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] m;
      m = (n == COUNT_W'(COLOUR_MODULUS)) ? '0 : n;
      return LEVEL_W'(m * LEVEL_W'(COLOUR_MULT));
   endfunction

   function automatic logic [LEVEL_W-1:0] red_of(input logic [COUNT_W-1:0] n);
      return LEVEL_W'(n * n);
   endfunction

endpackage

`default_nettype wire

// ===== design/mbrot_req_if.sv =====
// Pixel request channel: column and row with valid/ready.
`default_nettype none

interface mbrot_req_if import mbrot_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] column;
   logic [ROW_W-1:0] row;

   modport source (output valid, output column, output row, input ready);
   modport sink (input valid, input column, input row, output ready);
endinterface

`default_nettype wire

// ===== design/mbrot_rsp_if.sv =====
// Pixel result channel: address, count and colour with valid/ready.
`default_nettype none

interface mbrot_rsp_if import mbrot_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  pixel_address;
   logic [COUNT_W-1:0] iteration_count;
   logic [LEVEL_W-1:0] blue_green_level;
   logic [LEVEL_W-1:0] red_level;

   modport source (output valid, output pixel_address, output iteration_count,
                   output blue_green_level, output red_level, input ready);
   modport sink (input valid, input pixel_address, input iteration_count,
                 input blue_green_level, input red_level, output ready);
endinterface

`default_nettype wire

// ===== design/mandelbrot_escape_time_pixel_core.sv =====
// Top level of the Mandelbrot escape-time pixel core: control registers, front end, queue, engine.
// Each request beat (column, row) is mapped to c = ((column - W/2 + offset_x) * step_x,
// (row - H/2 + offset_y) * step_y) in 40-bit fixed point and iterated as z = z*z + c from z = c
// until |z|^2 reaches escape_threshold or iteration_limit iterations are done; one result beat
// carries the frame-buffer address, the count n and its colour. The front end takes a new
// pixel every cycle while the queue has room and maps it through the offset and product register
// stages; the engine then iterates one pixel at a time, each iteration running x*x, y*y and x*y
// on a 40x20 multiplier in two passes, then merging the partial products, then testing and
// updating z. A two-entry queue and the output register let the front end and the result side
// stall independently of the engine. The user must write the control registers through the csr
// port only while no pixel is in flight; the core itself does not enforce this.
`default_nettype none

module mandelbrot_escape_time_pixel_core import mbrot_pkg::*; #(
   parameter int IMAGE_WIDTH   = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT  = DEF_IMAGE_HEIGHT,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS,
   parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   mbrot_req_if.sink              req_bus,
   mbrot_rsp_if.source            rsp_bus,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      push, pop, full, empty;
   point_type push_item, pop_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_OFFSET_X:         cfg_in.offset_x = $signed(csr_wdata[OFFSET_W-1:0]);
            CSR_OFFSET_Y:         cfg_in.offset_y = $signed(csr_wdata[OFFSET_W-1:0]);
            CSR_STEP_X:           cfg_in.step_x = csr_wdata[STEP_W-1:0];
            CSR_STEP_Y:           cfg_in.step_y = csr_wdata[STEP_W-1:0];
            CSR_ITERATION_LIMIT:  cfg_in.iteration_limit = csr_wdata[LIMIT_W-1:0];
            CSR_ESCAPE_THRESHOLD: cfg_in.escape_threshold = csr_wdata[THRESH_W-1:0];
            default: ; // drop writes to unmapped indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbrot_front #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg_ff),
      .full      (full),
      .push      (push),
      .push_item (push_item)
   );

   mbrot_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (empty)
   );

   mbrot_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .empty    (empty),
      .pop_item (pop_item),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== design/mbrot_front.sv =====
// Front end: takes pixel beats, maps them to complex points and pushes them to the queue.
`default_nettype none

module mbrot_front import mbrot_pkg::*; #(
   parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
   input  logic          clock,
   input  logic          reset,
   mbrot_req_if.sink     req_bus,
   input  cfg_type       cfg,
   input  logic          full,
   output logic          push,
   output point_type     push_item
);

   localparam int K_W         = OFFSET_W + 2;
   localparam int PROD_W      = K_W + STEP_W + 1;
   localparam int ADDR_FULL_W = COL_W + ROW_W + $clog2(IMAGE_WIDTH + 1);
   localparam logic signed [K_W-1:0] HALF_COLS = K_W'(IMAGE_WIDTH / 2);
   localparam logic signed [K_W-1:0] HALF_ROWS = K_W'(IMAGE_HEIGHT / 2);

   logic                     en;
   logic                     req_fire;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s2_valid_ff, s2_valid_in;
   logic signed [K_W-1:0]    kx_ff, kx_in, ky_ff, ky_in;
   logic [ADDR_W-1:0]        addr1_ff, addr1_in, addr2_ff;
   logic signed [PROD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [FX_W-1:0]   cx_sat, cy_sat;

   // Stall the whole front while the last stage waits on a full queue
   assign en       = !(s2_valid_ff && full);
   assign req_fire = req_bus.valid && en;
   assign req_bus.ready = en;

   always_comb begin
      kx_in = K_W'($signed({1'b0, req_bus.column})) - HALF_COLS + K_W'($signed(cfg.offset_x));
      ky_in = K_W'($signed({1'b0, req_bus.row})) - HALF_ROWS + K_W'($signed(cfg.offset_y));
      addr1_in = ADDR_W'(ADDR_FULL_W'(req_bus.column)
                 + ADDR_FULL_W'(req_bus.row) * ADDR_FULL_W'(IMAGE_WIDTH));
      px_in = PROD_W'(kx_ff) * PROD_W'($signed({1'b0, cfg.step_x}));
      py_in = PROD_W'(ky_ff) * PROD_W'($signed({1'b0, cfg.step_y}));
      s1_valid_in = en ? req_fire : s1_valid_ff;
      s2_valid_in = en ? s1_valid_ff : s2_valid_ff;
   end

   // Clamp the exact coordinate products to the fixed-point range
   always_comb begin
      if (&px_ff[PROD_W-1:FX_W-1] || ~|px_ff[PROD_W-1:FX_W-1]) begin
         cx_sat = px_ff[FX_W-1:0];
      end else begin
         cx_sat = px_ff[PROD_W-1] ? FX_MIN : FX_MAX;
      end
      if (&py_ff[PROD_W-1:FX_W-1] || ~|py_ff[PROD_W-1:FX_W-1]) begin
         cy_sat = py_ff[FX_W-1:0];
      end else begin
         cy_sat = py_ff[PROD_W-1] ? FX_MIN : FX_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kx_ff    <= kx_in;
         ky_ff    <= ky_in;
         addr1_ff <= addr1_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         addr2_ff <= addr1_ff;
      end
   end

   assign push = s2_valid_ff && !full;
   assign push_item.cx = cx_sat;
   assign push_item.cy = cy_sat;
   assign push_item.pixel_address = addr2_ff;

endmodule

`default_nettype wire

// ===== design/mbrot_queue.sv =====
// Short point queue between the front end and the iteration engine.
`default_nettype none

module mbrot_queue import mbrot_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  point_type push_item,
   output logic      full,
   input  logic      pop,
   output point_type pop_item,
   output logic      empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   point_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("point pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("point popped from an empty queue");

endmodule

`default_nettype wire

// ===== design/mbrot_back.sv =====
// Iteration engine: runs z = z*z + c on three shared 40x20 multipliers and emits result beats.
`default_nettype none

module mbrot_back import mbrot_pkg::*; #(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        empty,
   input  point_type   pop_item,
   output logic        pop,
   mbrot_rsp_if.source rsp_bus
);

   localparam int LANES  = 3;
   localparam int PP_W   = FX_W + HALF_W;
   localparam int WIDE_W = 2 * FX_W;
   localparam logic [WIDE_W-1:0] FRAC_MASK = (WIDE_W'(1) << FRACTION_BITS) - WIDE_W'(1);

   back_state_type state_ff, state_in;

   logic signed [FX_W-1:0] x_ff, x_in, y_ff, y_in, cx_ff, cy_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [COUNT_W-1:0]     n_ff, n_in;
   logic [PP_W-1:0]        hi_ff [LANES];
   logic [PP_W-1:0]        lo_ff [LANES];
   logic [PP_W-1:0]        pp [LANES];
   logic signed [FX_W-1:0] prod_ff [LANES];
   logic signed [FX_W-1:0] prod_in [LANES];
   logic [FX_W-1:0]        op_a [LANES];
   logic [FX_W-1:0]        op_b [LANES];
   logic [HALF_W-1:0]      mul_b [LANES];
   logic                   lane_neg [LANES];
   logic [FX_W-1:0]        mag_x, mag_y;

   logic signed [FX_W-1:0] r_sum, x_next, y_next;
   logic                   escaped;
   logic                   out_free;

   logic load_point, capture_hi, capture_lo, capture_prod, do_update, load_out;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [LEVEL_W-1:0] rsp_bg_ff, rsp_red_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Lane operands: x*x, y*y and x*y on magnitudes, sign applied after the shift
   always_comb begin
      mag_x = x_ff[FX_W-1] ? FX_W'(-x_ff) : FX_W'(x_ff);
      mag_y = y_ff[FX_W-1] ? FX_W'(-y_ff) : FX_W'(y_ff);
      op_a[0] = mag_x;  op_b[0] = mag_x;  lane_neg[0] = 1'b0;
      op_a[1] = mag_y;  op_b[1] = mag_y;  lane_neg[1] = 1'b0;
      op_a[2] = mag_x;  op_b[2] = mag_y;  lane_neg[2] = x_ff[FX_W-1] ^ y_ff[FX_W-1];
      for (int i = 0; i < LANES; i++) begin
         mul_b[i] = (state_ff == ST_MUL_HI) ? op_b[i][FX_W-1:HALF_W] : op_b[i][HALF_W-1:0];
         pp[i]    = PP_W'(op_a[i]) * PP_W'(mul_b[i]);
      end
   end

   // Merge partial products, drop the fraction rounding toward minus infinity, clamp
   always_comb begin
      logic [WIDE_W-1:0] full_p;
      logic [WIDE_W-1:0] q;
      logic [WIDE_W-1:0] qc;
      for (int i = 0; i < LANES; i++) begin
         full_p = (WIDE_W'(hi_ff[i]) << HALF_W) + WIDE_W'(lo_ff[i]);
         q      = full_p >> FRACTION_BITS;
         qc     = q + WIDE_W'(|(full_p & FRAC_MASK));
         if (lane_neg[i]) begin
            prod_in[i] = (|qc[WIDE_W-1:FX_W-1]) ? FX_MIN : -$signed(qc[FX_W-1:0]);
         end else begin
            prod_in[i] = (|q[WIDE_W-1:FX_W-1]) ? FX_MAX : $signed(q[FX_W-1:0]);
         end
      end
   end

   // Escape test and next z
   always_comb begin
      r_sum   = sat_fx((FX_W+2)'(prod_ff[0]) + (FX_W+2)'(prod_ff[1]));
      escaped = (r_sum >= $signed(FX_W'(cfg.escape_threshold)));
      x_next  = sat_fx((FX_W+2)'(prod_ff[0]) - (FX_W+2)'(prod_ff[1]) + (FX_W+2)'(cx_ff));
      y_next  = sat_fx(((FX_W+2)'(prod_ff[2]) <<< 1) + (FX_W+2)'(cy_ff));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               state_in = (cfg.iteration_limit == '0) ? ST_DONE : ST_MUL_HI;
            end
         end
         ST_MUL_HI:  state_in = ST_MUL_LO;
         ST_MUL_LO:  state_in = ST_COMBINE;
         ST_COMBINE: state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (escaped || (n_ff + COUNT_W'(1) == cfg.iteration_limit)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL_HI;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controls
   always_comb begin
      load_point   = 1'b0;
      capture_hi   = 1'b0;
      capture_lo   = 1'b0;
      capture_prod = 1'b0;
      do_update    = 1'b0;
      load_out     = 1'b0;
      unique case (state_ff)
         ST_IDLE:    load_point   = !empty;
         ST_MUL_HI:  capture_hi   = 1'b1;
         ST_MUL_LO:  capture_lo   = 1'b1;
         ST_COMBINE: capture_prod = 1'b1;
         ST_UPDATE:  do_update    = !escaped;
         ST_DONE:    load_out     = out_free;
         default: ;
      endcase
   end

   assign pop = load_point;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      n_in = n_ff;
      if (load_point) begin
         x_in = pop_item.cx;
         y_in = pop_item.cy;
         n_in = '0;
      end else if (do_update) begin
         x_in = x_next;
         y_in = y_next;
         n_in = n_ff + COUNT_W'(1);
      end
      rsp_valid_in = load_out ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      n_ff <= n_in;
      if (load_point) begin
         cx_ff   <= pop_item.cx;
         cy_ff   <= pop_item.cy;
         addr_ff <= pop_item.pixel_address;
      end
      for (int i = 0; i < LANES; i++) begin
         if (capture_hi) begin
            hi_ff[i] <= pp[i];
         end
         if (capture_lo) begin
            lo_ff[i] <= pp[i];
         end
         if (capture_prod) begin
            prod_ff[i] <= prod_in[i];
         end
      end
      if (load_out) begin
         rsp_addr_ff  <= addr_ff;
         rsp_count_ff <= n_ff;
         rsp_bg_ff    <= blue_green_of(n_ff);
         rsp_red_ff   <= red_of(n_ff);
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.pixel_address    = rsp_addr_ff;
   assign rsp_bus.iteration_count  = rsp_count_ff;
   assign rsp_bus.blue_green_level = rsp_bg_ff;
   assign rsp_bus.red_level        = rsp_red_ff;

   a_squares_non_negative: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (!prod_ff[0][FX_W-1] && !prod_ff[1][FX_W-1]))
      else $error("squared term came out negative");

   a_count_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != ST_IDLE) && ($past(state_ff) != ST_IDLE) && !$past(reset))
      |-> ((n_ff == $past(n_ff)) || (n_ff == $past(n_ff) + COUNT_W'(1))))
      else $error("iteration count jumped within one pixel");

   a_done_loads_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished pixel did not reach the output register");

endmodule

`default_nettype wire

// ===== bench/mbrot_checker.sv =====
// Checker for the pixel core: watches the channels, predicts each result and compares.
`timescale 1ns / 1ps

module mbrot_checker import mbrot_pkg::*; #(
   parameter int IMAGE_WIDTH   = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT  = DEF_IMAGE_HEIGHT,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   mbrot_req_if                   req_mon,
   mbrot_rsp_if                   rsp_mon,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     outstanding
);

   typedef struct packed {
      logic [ADDR_W-1:0]  pixel_address;
      logic [COUNT_W-1:0] iteration_count;
      logic [LEVEL_W-1:0] blue_green_level;
      logic [LEVEL_W-1:0] red_level;
   } pixel_result_type;

   localparam longint FX_TOP    = longint'(FX_MAX);
   localparam longint FX_BOTTOM = longint'(FX_MIN);

   cfg_type          settings;
   pixel_result_type pixel_q[$];

   function automatic longint clamp_fx(input longint v);
      longint res;
      if (v > FX_TOP) begin
         res = FX_TOP;
      end else if (v < FX_BOTTOM) begin
         res = FX_BOTTOM;
      end else begin
         res = v;
      end
      return res;
   endfunction

   // Exact product, floored by the fraction shift, then clamped
   function automatic longint fx_product(input longint a, input longint b);
      logic signed [79:0] p;
      logic signed [79:0] q;
      longint res;
      p = a * b;
      q = p >>> FRACTION_BITS;
      if (q > FX_TOP) begin
         res = FX_TOP;
      end else if (q < FX_BOTTOM) begin
         res = FX_BOTTOM;
      end else begin
         res = longint'(q);
      end
      return res;
   endfunction

   function automatic pixel_result_type escape_pixel(input logic [COL_W-1:0] col,
                                                     input logic [ROW_W-1:0] row,
                                                     input cfg_type c);
      longint kx, ky, cx, cy, x, y, xs, ys, xy, r;
      int n;
      pixel_result_type res;
      kx = longint'(col) - longint'(IMAGE_WIDTH / 2) + longint'($signed(c.offset_x));
      ky = longint'(row) - longint'(IMAGE_HEIGHT / 2) + longint'($signed(c.offset_y));
      cx = clamp_fx(kx * longint'(c.step_x));
      cy = clamp_fx(ky * longint'(c.step_y));
      x = cx;
      y = cy;
      n = 0;
      while (n < int'(c.iteration_limit)) begin
         xs = fx_product(x, x);
         ys = fx_product(y, y);
         xy = fx_product(x, y);
         r = clamp_fx(xs + ys);
         if (r >= longint'(c.escape_threshold)) break;
         x = clamp_fx(xs - ys + cx);
         y = clamp_fx(xy + xy + cy);
         n++;
      end
      res.pixel_address    = ADDR_W'(int'(col) + int'(row) * IMAGE_WIDTH);
      res.iteration_count  = COUNT_W'(n);
      res.blue_green_level = LEVEL_W'((n % COLOUR_MODULUS) * COLOUR_MULT);
      res.red_level        = LEVEL_W'(n * n);
      return res;
   endfunction

   function automatic int field_differs(input string name, input int unsigned want,
                                        input int unsigned got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      pixel_result_type want;
      int errs;
      if (reset) begin
         settings.offset_x         <= -21'sd400;
         settings.offset_y         <= 21'sd0;
         settings.step_x           <= 29'd603980;
         settings.step_y           <= 29'd603980;
         settings.iteration_limit  <= 8'd255;
         settings.escape_threshold <= 36'd2684354560;
         pixel_q.delete();
         outstanding <= 0;
      end else begin
         errs = 0;
         if (csr_write_en) begin
            case (csr_index)
               CSR_OFFSET_X:         settings.offset_x <= csr_wdata[OFFSET_W-1:0];
               CSR_OFFSET_Y:         settings.offset_y <= csr_wdata[OFFSET_W-1:0];
               CSR_STEP_X:           settings.step_x <= csr_wdata[STEP_W-1:0];
               CSR_STEP_Y:           settings.step_y <= csr_wdata[STEP_W-1:0];
               CSR_ITERATION_LIMIT:  settings.iteration_limit <= csr_wdata[LIMIT_W-1:0];
               CSR_ESCAPE_THRESHOLD: settings.escape_threshold <= csr_wdata[THRESH_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pixel_q.size() == 0) begin
               $display("%0t unexpected result beat: expected none actual address %0d",
                        $time, rsp_mon.pixel_address);
               errs++;
            end else begin
               want = pixel_q.pop_front();
               errs += field_differs("pixel_address", want.pixel_address,
                                     rsp_mon.pixel_address);
               errs += field_differs("iteration_count", want.iteration_count,
                                     rsp_mon.iteration_count);
               errs += field_differs("blue_green_level", want.blue_green_level,
                                     rsp_mon.blue_green_level);
               errs += field_differs("red_level", want.red_level, rsp_mon.red_level);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pixel_q.push_back(escape_pixel(req_mon.column, req_mon.row, settings));
         end
         fail_count  <= fail_count + errs;
         outstanding <= pixel_q.size();
      end
   end

endmodule

// ===== bench/testbench.sv =====
// Bench top for the pixel core: clock, reset, pixel stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
   import mbrot_pkg::*;

   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 82;
   localparam int SETTLE_CYCLES   = 1100;

   // Indexes past the register list; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum int {FLOW_OPEN, FLOW_COIN, FLOW_COMB, FLOW_SPARSE} flow_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     outstanding;
   int                     cycle_count = 0;
   int                     burst_left;

   mbrot_req_if req_bus ();
   mbrot_rsp_if rsp_bus ();

   mandelbrot_escape_time_pixel_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   mbrot_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side: stall on a random pattern that is chosen anew whenever its span runs out
   initial begin : receiver
      flow_mode_type mode;
      int span;
      rsp_bus.ready <= 1'b0;
      mode = FLOW_OPEN;
      span = 0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            mode = flow_mode_type'($urandom_range(0, 3));
            span = $urandom_range(20, 300);
         end
         span--;
         case (mode)
            FLOW_OPEN:  rsp_bus.ready <= 1'b1;
            FLOW_COIN:  rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            FLOW_COMB:  rsp_bus.ready <= ((span % 7) > 2);
            default:    rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic signed [OFFSET_W-1:0] ox,
                                input logic signed [OFFSET_W-1:0] oy,
                                input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy,
                                input logic [LIMIT_W-1:0] lim,
                                input logic [THRESH_W-1:0] thr);
      write_reg(CSR_OFFSET_X, CSR_DATA_W'(ox));
      write_reg(CSR_OFFSET_Y, CSR_DATA_W'(oy));
      write_reg(CSR_STEP_X, CSR_DATA_W'(sx));
      write_reg(CSR_STEP_Y, CSR_DATA_W'(sy));
      write_reg(CSR_ITERATION_LIMIT, CSR_DATA_W'(lim));
      write_reg(CSR_ESCAPE_THRESHOLD, CSR_DATA_W'(thr));
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Hold the beat until taken; close the burst with a random gap
   task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      req_bus.valid  <= 1'b1;
      req_bus.column <= col;
      req_bus.row    <= row;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      logic signed [OFFSET_W-1:0] ox, oy;
      logic [STEP_W-1:0]          sx, sy;
      logic [LIMIT_W-1:0]         lim;
      logic [THRESH_W-1:0]        thr;
      logic [COL_W-1:0]           col;
      logic [ROW_W-1:0]           row;
      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_OFFSET_X;
      csr_wdata      <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.column <= '0;
      req_bus.row    <= '0;
      burst_left = $urandom_range(1, 12);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings; spare indexes must leave them alone
      write_reg(CSR_SPARE_LO, CSR_DATA_W'({$urandom, $urandom}));
      write_reg(CSR_SPARE_HI, CSR_DATA_W'({$urandom, $urandom}));
      csr_write_en <= 1'b0;
      @(posedge clock);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd799, 10'd599);
      send_pixel(10'd800, 10'd300);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd400, 10'd300);
      drain();

      // Coordinates clamp at both ends of the range
      load_settings(-21'sd1048576, 21'sd1048575, 29'h1FFF_FFFF, 29'h1FFF_FFFF, 8'd255,
                    36'hF_FFFF_FFFF);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd400, 10'd300);
      drain();

      // No iterations allowed
      load_settings(-21'sd400, 21'sd0, 29'd603980, 29'd603980, 8'd0, 36'd2684354560);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd800, 10'd300);
      drain();

      // Zero threshold: escape at once
      load_settings(21'sd0, 21'sd0, 29'h1000_0000, 29'd0, 8'd255, 36'd0);
      send_pixel(10'd400, 10'd300);
      send_pixel(10'd401, 10'd300);
      drain();

      // Zero step on both axes: z stays at the origin until the limit
      load_settings(21'sd0, 21'sd0, 29'd0, 29'd0, 8'd255, 36'd1);
      send_pixel(10'd3, 10'd4);
      drain();

      // Smallest step, single iteration
      load_settings(21'sd1048575, 21'sd1048575, 29'd1, 29'd1, 8'd1, 36'd1);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd599);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         ox = ($urandom_range(0, 5) == 0) ? OFFSET_W'($urandom)
                                           : OFFSET_W'(int'($urandom_range(0, 400)) - 450);
         oy = ($urandom_range(0, 5) == 0) ? OFFSET_W'($urandom)
                                           : OFFSET_W'(int'($urandom_range(0, 200)) - 100);
         sx = ($urandom_range(0, 5) == 0) ? STEP_W'($urandom)
                                           : STEP_W'($urandom_range(300000, 1200000));
         sy = ($urandom_range(0, 5) == 0) ? STEP_W'($urandom)
                                           : STEP_W'($urandom_range(300000, 1200000));
         if (p == 0) begin
            lim = 8'd255;
         end else if ($urandom_range(0, 4) == 0) begin
            lim = LIMIT_W'($urandom_range(0, 255));
         end else begin
            lim = LIMIT_W'($urandom_range(1, 48));
         end
         case ($urandom_range(0, 3))
            0:       thr = 36'd1 << 30;
            1:       thr = 36'd2684354560;
            2:       thr = THRESH_W'($urandom_range(32'h0100_0000, 32'h8000_0000));
            default: thr = THRESH_W'({$urandom, $urandom});
         endcase
         load_settings(ox, oy, sx, sy, lim, thr);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               col = COL_W'($urandom_range(0, 1023));
               row = ROW_W'($urandom_range(0, 1023));
            end else begin
               col = COL_W'($urandom_range(0, 799));
               row = ROW_W'($urandom_range(0, 599));
            end
            send_pixel(col, row);
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
